@@ hw/rtl/irb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irb_pkg
// shared types and codes for the ir code word builder
// ----------------------------------------------------------------------------
package irb_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SelW      = 4;
  localparam int unsigned FamW      = 3;
  localparam int unsigned WordW     = 32;
  localparam int unsigned BitCountW = 6;
  localparam int unsigned InDataW   = 4 * ByteW;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned OutUserW  = 1 + FamW;

  typedef enum logic [SelW-1:0] {
    PROTO_NEC       = 4'd0,
    PROTO_NECEXT    = 4'd1,
    PROTO_SAMSUNG32 = 4'd2,
    PROTO_RC5       = 4'd3,
    PROTO_RC5X      = 4'd4,
    PROTO_RC6       = 4'd5,
    PROTO_SIRC      = 4'd6,
    PROTO_SIRC15    = 4'd7,
    PROTO_SIRC20    = 4'd8,
    PROTO_JVC       = 4'd9,
    PROTO_LG        = 4'd10
  } proto_t;

  typedef enum logic [FamW-1:0] {
    FAM_UNKNOWN = 3'd0,
    FAM_NEC     = 3'd1,
    FAM_SAMSUNG = 3'd2,
    FAM_RC5     = 3'd3,
    FAM_RC6     = 3'd4,
    FAM_SONY    = 3'd5,
    FAM_JVC     = 3'd6,
    FAM_LG      = 3'd7
  } family_t;

  typedef struct packed {
    logic [SelW-1:0]  protocol_select;
    logic [ByteW-1:0] address_low;
    logic [ByteW-1:0] address_high;
    logic [ByteW-1:0] command_low;
    logic [ByteW-1:0] command_high;
  } in_item_t;

  typedef struct packed {
    logic                 ok;
    logic [FamW-1:0]      family_code;
    logic [WordW-1:0]     code_word;
    logic [BitCountW-1:0] bit_count;
  } out_item_t;

endpackage

@@ hw/rtl/ir_remote_code_word_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_code_word_builder
// builds the on-air ir code word for a selected remote protocol
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side channel takes one request per transfer: the protocol
//   selector in in_tuser and the address and command bytes in in_tdata.
//   The master-side channel returns one result per request, in order:
//   ok flag and family code in out_tuser, code word and bit count in
//   out_tdata. An unknown selector gives ok low and all other fields zero.
//   A request passes through the input register, then the encoding logic
//   into the result register, before its result transfer is offered.
//   Throughput is one transfer per cycle while out_tready stays high; each
//   stage takes a new item in the same cycle its old one moves on.
//   Reset (rst_n low, synchronous) empties both stages; no result is shown
//   afterwards until a new request arrives.
//   While out_tready is low the result is held; an empty input register
//   still takes one request, then in_tready stays low until the result moves.
// ----------------------------------------------------------------------------
module ir_remote_code_word_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // address_low, address_high, command_low, command_high
  input  logic [irb_pkg::InDataW-1:0]      in_tdata,
  // protocol_select
  input  logic [irb_pkg::SelW-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // code_word, bit_count, zero pad
  output logic [irb_pkg::OutDataW-1:0]     out_tdata,
  // ok, family_code
  output logic [irb_pkg::OutUserW-1:0]     out_tuser
);

  logic               item_valid;
  logic               res_ready;
  irb_pkg::in_item_t  item;
  irb_pkg::out_item_t res;

  irb_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .next_ready (res_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  irb_encode u_encode (
    .item (item),
    .res  (res)
  );

  irb_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hw/rtl/irb_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irb_in_stage
// input register: captures one transfer from the slave-side channel
// ----------------------------------------------------------------------------
module irb_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [irb_pkg::InDataW-1:0]     in_tdata,
  input  logic [irb_pkg::SelW-1:0]        in_tuser,
  input  logic                            next_ready,
  output logic                            item_valid,
  output irb_pkg::in_item_t               item
);

  logic              valid_r;
  logic              valid_nxt;
  irb_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || next_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.protocol_select <= in_tuser;
      item_r.address_low     <= in_tdata[7:0];
      item_r.address_high    <= in_tdata[15:8];
      item_r.command_low     <= in_tdata[23:16];
      item_r.command_high    <= in_tdata[31:24];
    end
  end

endmodule

@@ hw/rtl/irb_encode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irb_encode
// per-protocol bit packing, reversal and checksum
// ----------------------------------------------------------------------------
module irb_encode (
  input  irb_pkg::in_item_t  item,
  output irb_pkg::out_item_t res
);

  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic [7:0]  ra;
  logic [7:0]  rc;
  logic [15:0] rext;
  logic [11:0] sirc12;
  logic [14:0] sirc15;
  logic [19:0] sirc20;
  logic [15:0] jvc16;
  logic [3:0]  chk;

  assign a0 = item.address_low;
  assign a1 = item.address_high;
  assign c0 = item.command_low;
  assign c1 = item.command_high;

  always_comb begin
    ra     = {<<{a0}};
    rc     = {<<{c0}};
    rext   = {<<{{a1, a0}}};
    sirc12 = {<<{{a0[4:0], c0[6:0]}}};
    sirc15 = {<<{{a0, c0[6:0]}}};
    sirc20 = {<<{{a1[4:0], a0, c0[6:0]}}};
    jvc16  = {<<{{c0, a0}}};
    chk    = a0[7:4] + a0[3:0] + c0[7:4] + c0[3:0] + c1[7:4] + c1[3:0];

    res.ok          = 1'b1;
    res.family_code = irb_pkg::FAM_UNKNOWN;
    res.code_word   = '0;
    res.bit_count   = '0;
    unique case (item.protocol_select)
      irb_pkg::PROTO_NEC: begin
        res.family_code = irb_pkg::FAM_NEC;
        res.bit_count   = 6'd32;
        res.code_word   = {ra, ~ra, rc, ~rc};
      end
      irb_pkg::PROTO_NECEXT: begin
        res.family_code = irb_pkg::FAM_NEC;
        res.bit_count   = 6'd32;
        res.code_word   = {rext, rc, ~rc};
      end
      irb_pkg::PROTO_SAMSUNG32: begin
        res.family_code = irb_pkg::FAM_SAMSUNG;
        res.bit_count   = 6'd32;
        res.code_word   = {ra, ra, rc, ~rc};
      end
      irb_pkg::PROTO_RC5: begin
        res.family_code = irb_pkg::FAM_RC5;
        res.bit_count   = 6'd12;
        res.code_word   = {21'd0, a0[4:0], c0[5:0]};
      end
      irb_pkg::PROTO_RC5X: begin
        res.family_code = irb_pkg::FAM_RC5;
        res.bit_count   = 6'd13;
        res.code_word   = {20'd0, a0[4:0], c0[6:0]};
      end
      irb_pkg::PROTO_RC6: begin
        res.family_code = irb_pkg::FAM_RC6;
        res.bit_count   = 6'd20;
        res.code_word   = {16'd0, a0, c0};
      end
      irb_pkg::PROTO_SIRC: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd12;
        res.code_word   = {20'd0, sirc12};
      end
      irb_pkg::PROTO_SIRC15: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd15;
        res.code_word   = {17'd0, sirc15};
      end
      irb_pkg::PROTO_SIRC20: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd20;
        res.code_word   = {12'd0, sirc20};
      end
      irb_pkg::PROTO_JVC: begin
        res.family_code = irb_pkg::FAM_JVC;
        res.bit_count   = 6'd16;
        res.code_word   = {16'd0, jvc16};
      end
      irb_pkg::PROTO_LG: begin
        res.family_code = irb_pkg::FAM_LG;
        res.bit_count   = 6'd28;
        res.code_word   = {4'd0, a0, c1, c0, chk};
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/irb_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irb_out_stage
// result register driving the master-side channel
// ----------------------------------------------------------------------------
module irb_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             res_valid,
  output logic                             res_ready,
  input  irb_pkg::out_item_t               res,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [irb_pkg::OutDataW-1:0]     out_tdata,
  output logic [irb_pkg::OutUserW-1:0]     out_tuser
);

  logic               valid_r;
  logic               valid_nxt;
  irb_pkg::out_item_t res_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {2'd0, res_r.bit_count, res_r.code_word};
  assign out_tuser  = {res_r.family_code, res_r.ok};

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

@@ tb/sv/ir_remote_code_word_builder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irb_code_word_checker
// watches both stream channels of the ir code word builder, works out the
// code word for every accepted request and compares it, in order, with each
// result transfer
// ----------------------------------------------------------------------------
module irb_code_word_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // address_low, address_high, command_low, command_high
  input  logic [irb_pkg::InDataW-1:0]    in_tdata,
  // protocol_select
  input  logic [irb_pkg::SelW-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // code_word, bit_count, zero pad
  input  logic [irb_pkg::OutDataW-1:0]   out_tdata,
  // ok, family_code
  input  logic [irb_pkg::OutUserW-1:0]   out_tuser,
  output int unsigned                    error_count,
  output int unsigned                    pending
);

  localparam int unsigned WordW     = irb_pkg::WordW;
  localparam int unsigned BitCountW = irb_pkg::BitCountW;
  localparam int unsigned ExpDepth  = 256;

  irb_pkg::out_item_t expected_words [ExpDepth];
  logic [7:0]         wr_idx;
  logic [7:0]         rd_idx;
  int unsigned        exp_count;

  function automatic logic [WordW-1:0] reverse_bits(logic [WordW-1:0] v, int unsigned n);
    logic [WordW-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < n; i++) begin
      r = {r[WordW-2:0], v[i]};
    end
    return r;
  endfunction

  function automatic irb_pkg::out_item_t encode_code_word(irb_pkg::in_item_t req);
    irb_pkg::out_item_t res;
    logic [WordW-1:0]   a0, a1, c0, c1, ra, rc, chk;
    a0  = WordW'(req.address_low);
    a1  = WordW'(req.address_high);
    c0  = WordW'(req.command_low);
    c1  = WordW'(req.command_high);
    ra  = reverse_bits(a0, 8);
    rc  = reverse_bits(c0, 8);
    res = '0;
    res.ok = 1'b1;
    case (req.protocol_select)
      irb_pkg::PROTO_NEC: begin
        res.family_code = irb_pkg::FAM_NEC;
        res.bit_count   = 6'd32;
        res.code_word   = (ra << 24) | ((ra ^ 32'hFF) << 16) | (rc << 8) | (rc ^ 32'hFF);
      end
      irb_pkg::PROTO_NECEXT: begin
        res.family_code = irb_pkg::FAM_NEC;
        res.bit_count   = 6'd32;
        res.code_word   = (reverse_bits(a0 | (a1 << 8), 16) << 16) | (rc << 8)
                          | (rc ^ 32'hFF);
      end
      irb_pkg::PROTO_SAMSUNG32: begin
        res.family_code = irb_pkg::FAM_SAMSUNG;
        res.bit_count   = 6'd32;
        res.code_word   = (ra << 24) | (ra << 16) | (rc << 8) | (rc ^ 32'hFF);
      end
      irb_pkg::PROTO_RC5: begin
        res.family_code = irb_pkg::FAM_RC5;
        res.bit_count   = 6'd12;
        res.code_word   = ((a0 & 32'h1F) << 6) | (c0 & 32'h3F);
      end
      irb_pkg::PROTO_RC5X: begin
        res.family_code = irb_pkg::FAM_RC5;
        res.bit_count   = 6'd13;
        res.code_word   = ((a0 & 32'h1F) << 7) | (c0 & 32'h7F);
      end
      irb_pkg::PROTO_RC6: begin
        res.family_code = irb_pkg::FAM_RC6;
        res.bit_count   = 6'd20;
        res.code_word   = (a0 << 8) | c0;
      end
      irb_pkg::PROTO_SIRC: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd12;
        res.code_word   = reverse_bits(((a0 & 32'h1F) << 7) | (c0 & 32'h7F), 12);
      end
      irb_pkg::PROTO_SIRC15: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd15;
        res.code_word   = reverse_bits((a0 << 7) | (c0 & 32'h7F), 15);
      end
      irb_pkg::PROTO_SIRC20: begin
        res.family_code = irb_pkg::FAM_SONY;
        res.bit_count   = 6'd20;
        res.code_word   = reverse_bits((((a0 | (a1 << 8)) & 32'h1FFF) << 7)
                                       | (c0 & 32'h7F), 20);
      end
      irb_pkg::PROTO_JVC: begin
        res.family_code = irb_pkg::FAM_JVC;
        res.bit_count   = 6'd16;
        res.code_word   = reverse_bits((c0 << 8) | a0, 16);
      end
      irb_pkg::PROTO_LG: begin
        chk = (a0 >> 4) + (a0 & 32'hF) + (c0 >> 4) + (c0 & 32'hF)
              + (c1 >> 4) + (c1 & 32'hF);
        res.family_code = irb_pkg::FAM_LG;
        res.bit_count   = 6'd28;
        res.code_word   = (a0 << 20) | (((c1 << 8) | c0) << 4) | (chk & 32'hF);
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [WordW-1:0] exp, logic [WordW-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    irb_pkg::in_item_t  req;
    irb_pkg::out_item_t exp;
    if (!rst_n) begin
      wr_idx    = '0;
      rd_idx    = '0;
      exp_count = 0;
    end else begin
      // results first: a request taken at this edge cannot leave at the same edge
      if (out_tvalid && out_tready) begin
        if (exp_count == 0) begin
          $display("%0t: unexpected result, expected none actual %0h_%0h",
                   $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          exp       = expected_words[rd_idx];
          rd_idx    = rd_idx + 8'd1;
          exp_count = exp_count - 1;
          check_field("ok", WordW'(exp.ok), WordW'(out_tuser[0]));
          check_field("family_code", WordW'(exp.family_code), WordW'(out_tuser[3:1]));
          check_field("code_word", exp.code_word, out_tdata[WordW-1:0]);
          check_field("bit_count", WordW'(exp.bit_count),
                      WordW'(out_tdata[WordW+BitCountW-1:WordW]));
        end
      end
      if (in_tvalid && in_tready) begin
        req.protocol_select = in_tuser;
        req.address_low     = in_tdata[7:0];
        req.address_high    = in_tdata[15:8];
        req.command_low     = in_tdata[23:16];
        req.command_high    = in_tdata[31:24];
        expected_words[wr_idx] = encode_code_word(req);
        wr_idx    = wr_idx + 8'd1;
        exp_count = exp_count + 1;
      end
    end
    pending <= exp_count;
  end

endmodule

@@ tb/sv/tb_ir_remote_code_word_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_remote_code_word_builder
// drives protocol requests into the ir code word builder: a directed set of
// extremes for every protocol and unknown selectors, then random requests
// under several idle and stall mixes and one long output hold-off; the
// checker beside the block does the prediction and comparison
// ----------------------------------------------------------------------------
module tb_ir_remote_code_word_builder;

  localparam logic [irb_pkg::SelW-1:0] UNKNOWN_SEL_FIRST = 4'd11;
  localparam logic [irb_pkg::SelW-1:0] UNKNOWN_SEL_LAST  = 4'd15;
  localparam int unsigned              PHASE_ITEMS       = 80;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [irb_pkg::InDataW-1:0]    in_tdata   = '0;
  logic [irb_pkg::SelW-1:0]       in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [irb_pkg::OutDataW-1:0]   out_tdata;
  logic [irb_pkg::OutUserW-1:0]   out_tuser;

  int unsigned error_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off       = 1'b0;

  always #4 clk = ~clk;

  ir_remote_code_word_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  irb_code_word_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .error_count (error_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_request(irb_pkg::in_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.protocol_select;
    in_tdata  <= {req.command_high, req.command_low, req.address_high, req.address_low};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic irb_pkg::in_item_t random_request();
    irb_pkg::in_item_t req;
    logic [31:0]       rnd;
    if ($urandom_range(0, 9) == 0) begin
      rnd = $urandom_range(UNKNOWN_SEL_FIRST, UNKNOWN_SEL_LAST);
    end else begin
      rnd = $urandom_range(irb_pkg::PROTO_NEC, irb_pkg::PROTO_LG);
    end
    req.protocol_select = rnd[irb_pkg::SelW-1:0];
    {req.command_high, req.command_low, req.address_high, req.address_low} = $urandom;
    return req;
  endfunction

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
    end
  endtask

  initial begin
    irb_pkg::in_item_t req;
    irb_pkg::proto_t   proto;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every protocol at both byte extremes
    proto = proto.first();
    do begin
      req = '0;
      req.protocol_select = proto;
      send_request(req);
      req = '1;
      req.protocol_select = proto;
      send_request(req);
      proto = proto.next();
    end while (proto != proto.first());

    // unknown selectors
    req = '1;
    req.protocol_select = UNKNOWN_SEL_FIRST;
    send_request(req);
    req.protocol_select = UNKNOWN_SEL_LAST;
    send_request(req);
    req = '0;
    req.protocol_select = UNKNOWN_SEL_FIRST + 4'd2;
    send_request(req);

    send_random(PHASE_ITEMS);

    send_idle_pct = 80;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_stall_pct <= 80;
    send_random(PHASE_ITEMS);

    send_idle_pct = 32;
    recv_stall_pct <= 32;
    send_random(PHASE_ITEMS);

    // long output hold-off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_random(PHASE_ITEMS / 2);
    join
    send_random(PHASE_ITEMS / 2);

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("ir_remote_code_word_builder test passed");
    end else begin
      $display("ir_remote_code_word_builder test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ir_remote_code_word_builder test failed");
    $finish;
  end

endmodule

@@ ir_remote_code_word_builder.f @@
hw/rtl/irb_pkg.sv
hw/rtl/irb_in_stage.sv
hw/rtl/irb_encode.sv
hw/rtl/irb_out_stage.sv
hw/rtl/ir_remote_code_word_builder.sv
tb/sv/ir_remote_code_word_builder_checker.sv
tb/sv/tb_ir_remote_code_word_builder.sv
